### src/fwsr_pkg.sv
package fwsr_pkg;

  // default sizes of the queue
  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // stream port widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  // result field widths
  localparam int DATA_OUT_W = 32;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 5;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_DEQ,
    CMD_CONTAINS,
    CMD_REMOVE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_NOT_FOUND
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    set_st;
    status_t st;
    logic    enq;
    logic    scan;
    logic    shift;
    logic    deq;
    logic    out_load;
  } dp_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic walk_done;
  } dp_stat_t;

endpackage

### src/fwsr_datapath.sv
module fwsr_datapath #(
  parameter int DEPTH = fwsr_pkg::DEPTH_DEF,
  parameter int WIDTH = fwsr_pkg::WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fwsr_pkg::dp_ctrl_t                 ctrl,
  output fwsr_pkg::dp_stat_t                 stat,
  input  logic [fwsr_pkg::IN_DATA_W-1:0]     value,
  output logic [fwsr_pkg::DATA_OUT_W-1:0]    out_data,
  output fwsr_pkg::status_t                  out_status,
  output logic [fwsr_pkg::POS_W-1:0]         out_position,
  output logic [fwsr_pkg::COUNT_W-1:0]       out_count,
  output logic                               out_empty
);
  import fwsr_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data;
  logic [WIDTH-1:0] word_r;
  logic [WIDTH-1:0] data_r;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    ptr;
  logic [IW-1:0]    pend_idx;
  logic [IW-1:0]    base;
  logic             pend;
  logic             pend_first;
  logic             first;
  status_t          st_r;

  logic             issue;
  logic             hit;
  logic             walk_done;
  logic             full;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [WIDTH-1:0] wr_data;

  // walk status
  assign issue     = ptr < fill;
  assign hit       = pend && (rd_data == word_r);
  assign walk_done = !pend && !issue;
  assign full      = fill == CW'(DEPTH);
  assign rd_addr   = issue ? ptr[IW-1:0] : '0;

  assign stat.empty     = fill == '0;
  assign stat.full      = full;
  assign stat.hit       = hit;
  assign stat.walk_done = walk_done;

  // write port select: tail append or gap closing
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[IW-1:0];
    wr_data = word_r;
    if (ctrl.enq && !full) begin
      wr_en = 1'b1;
    end else if (ctrl.shift && pend && !pend_first) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx - 1'b1;
      wr_data = rd_data;
    end
  end

  // storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.enq && !full) begin
      fill <= fill + 1'b1;
    end else if (ctrl.shift && walk_done) begin
      fill <= fill - 1'b1;
    end
  end

  // walk pointer and in-flight read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (ctrl.load) begin
      pend <= 1'b0;
    end else if (ctrl.scan) begin
      pend <= hit ? 1'b0 : issue;
    end else if (ctrl.shift) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word_r <= WIDTH'(value);
      data_r <= '0;
      base   <= '0;
      ptr    <= '0;
      first  <= 1'b1;
      st_r   <= ST_OK;
    end else if (ctrl.scan) begin
      if (hit) begin
        // restart the walk at the match for a possible removal
        base  <= pend_idx;
        ptr   <= CW'(pend_idx);
        first <= 1'b1;
      end else begin
        pend_idx <= ptr[IW-1:0];
        if (issue) begin
          ptr <= ptr + 1'b1;
        end
      end
    end else if (ctrl.shift) begin
      pend_idx   <= ptr[IW-1:0];
      pend_first <= first;
      if (issue) begin
        ptr   <= ptr + 1'b1;
        first <= 1'b0;
      end
      // head word of a dequeue
      if (pend && pend_first && ctrl.deq) begin
        data_r <= rd_data;
      end
    end
    if (ctrl.set_st) begin
      st_r <= ctrl.st;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data     <= DATA_OUT_W'(data_r);
      out_status   <= st_r;
      out_position <= POS_W'(base);
      out_count    <= COUNT_W'(fill);
      out_empty    <= fill == '0;
    end
  end

endmodule

### src/fwsr_ctrl.sv
module fwsr_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fwsr_pkg::IN_USER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output fwsr_pkg::dp_ctrl_t             ctrl,
  input  fwsr_pkg::dp_stat_t             stat
);
  import fwsr_pkg::*;

  state_t state;
  state_t state_next;
  cmd_t   cmd_r;
  cmd_t   cmd_r_next;
  cmd_t   cmd_in;
  logic   out_valid;

  assign cmd_in   = cmd_t'(s_tuser);
  assign m_tvalid = out_valid;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd_r <= CMD_ENQ;
    end else begin
      state <= state_next;
      cmd_r <= cmd_r_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    cmd_r_next    = cmd_r;
    s_tready      = 1'b0;
    ctrl          = '0;
    ctrl.st       = ST_OK;
    ctrl.deq      = cmd_r == CMD_DEQ;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          cmd_r_next = cmd_in;
          unique case (cmd_in)
            CMD_ENQ: state_next = S_ENQ;
            CMD_DEQ: begin
              if (stat.empty) begin
                ctrl.set_st = 1'b1;
                ctrl.st     = ST_EMPTY;
                state_next  = S_DONE;
              end else begin
                state_next = S_SHIFT;
              end
            end
            CMD_CONTAINS, CMD_REMOVE: state_next = S_SCAN;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ENQ: begin
        ctrl.enq = 1'b1;
        if (stat.full) begin
          ctrl.set_st = 1'b1;
          ctrl.st     = ST_FULL;
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.hit) begin
          state_next = (cmd_r == CMD_REMOVE) ? S_SHIFT : S_DONE;
        end else if (stat.walk_done) begin
          ctrl.set_st = 1'b1;
          ctrl.st     = ST_NOT_FOUND;
          state_next  = S_DONE;
        end
      end
      S_SHIFT: begin
        ctrl.shift = 1'b1;
        if (stat.walk_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### src/fifo_with_search_and_remove.sv
// enqueue appends at the tail; dequeue closes the gap at the head, contains scans for
// the value, and remove scans for it and then closes the gap left by the match.
// these walks go through the storage with one write and one registered read port: a
// scan reads one entry a cycle, closing the gap moves one entry a cycle.
// synchronous active-high reset empties the queue and clears the handshakes;
// stored words are not cleared.
module fifo_with_search_and_remove #(
  parameter int DEPTH = fwsr_pkg::DEPTH_DEF,
  parameter int WIDTH = fwsr_pkg::WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fwsr_pkg::IN_DATA_W-1:0]  s_tdata,  // value[31:0]
  input  logic [fwsr_pkg::IN_USER_W-1:0]  s_tuser,  // cmd[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // data_out[31:0], status[33:32], position[37:34], count[42:38],
  // is_empty_flag[43], zero[47:44]
  output logic [fwsr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import fwsr_pkg::*;

  dp_ctrl_t                ctrl;
  dp_stat_t                stat;
  logic [DATA_OUT_W-1:0]   out_data;
  status_t                 out_status;
  logic [POS_W-1:0]        out_position;
  logic [COUNT_W-1:0]      out_count;
  logic                    out_empty;

  fwsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  fwsr_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .value        (s_tdata),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count),
    .out_empty    (out_empty)
  );

  // result item packing
  assign m_tdata = {4'b0, out_empty, out_count, out_position, out_status, out_data};

endmodule

### tb/fifo_with_search_and_remove_test.sv
module fifo_with_search_and_remove_test;
  import fwsr_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;

  typedef struct {
    logic [DATA_OUT_W-1:0] data;
    status_t               status;
    logic [POS_W-1:0]      pos;
    logic [COUNT_W-1:0]    count;
    logic                  empty;
  } outcome_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // value[31:0]
  logic [IN_USER_W-1:0]  s_tuser;   // cmd[1:0]
  logic                  m_tvalid;
  logic                  m_tready;
  // data_out[31:0], status[33:32], position[37:34], count[42:38],
  // is_empty_flag[43], zero[47:44]
  logic [OUT_DATA_W-1:0] m_tdata;

  // predicted queue contents, head first, and results still to come
  logic [WIDTH_DEF-1:0] stored_words[$];
  outcome_t             pending_results[$];
  outcome_t             oldest_result;
  int                   error_count = 0;
  bit                   gaps_on = 1'b0;
  bit                   rx_hold = 1'b0;

  logic [31:0] value_pool [6] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
                                  32'h8000_0000, 32'ha5a5_a5a5, 32'h5a5a_5a5a};

  fifo_with_search_and_remove dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // queue behavior for one accepted command, result goes to the pending list
  function automatic void apply_command(cmd_t c, logic [31:0] v);
    outcome_t o;
    int where;
    o = '{data: '0, status: ST_OK, pos: '0, count: '0, empty: 1'b0};
    where = -1;
    if (c == CMD_CONTAINS || c == CMD_REMOVE) begin
      foreach (stored_words[i])
        if (where < 0 && stored_words[i] == v) where = i;
    end
    case (c)
      CMD_ENQ: begin
        if (stored_words.size() >= QDEPTH) o.status = ST_FULL;
        else stored_words.push_back(v);
      end
      CMD_DEQ: begin
        if (stored_words.size() == 0) o.status = ST_EMPTY;
        else o.data = stored_words.pop_front();
      end
      default: begin
        if (where < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          o.pos = 4'(where);
          if (c == CMD_REMOVE) stored_words.delete(where);
        end
      end
    endcase
    o.count = 5'(stored_words.size());
    o.empty = (stored_words.size() == 0);
    pending_results.push_back(o);
  endfunction

  // mostly pool words or stored words so searches hit, some fully random
  function automatic logic [31:0] pick_value(bit searching);
    int r;
    r = $urandom_range(0, 9);
    if (searching && stored_words.size() != 0 && r < 6)
      return stored_words[$urandom_range(0, stored_words.size() - 1)];
    if (r < 8) return value_pool[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // one item on the input stream, valid stays high unless a gap follows
  task automatic send_cmd(cmd_t c, logic [31:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_command(c, v);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // stop sending until every predicted result has been seen
  task automatic wait_until_drained();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("data_out", oldest_result.data, m_tdata[31:0]);
        check_field("status", 32'(oldest_result.status), 32'(m_tdata[33:32]));
        check_field("position", 32'(oldest_result.pos), 32'(m_tdata[37:34]));
        check_field("count", 32'(oldest_result.count), 32'(m_tdata[42:38]));
        check_field("is_empty_flag", 32'(oldest_result.empty), 32'(m_tdata[43]));
      end
    end
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // dequeue, contains and remove on an empty queue
  task automatic test_empty_queue();
    send_cmd(CMD_DEQ, 32'h0);
    send_cmd(CMD_CONTAINS, 32'h0);
    send_cmd(CMD_REMOVE, 32'hffff_ffff);
  endtask

  // fill to full, overflow, search at the far end, remove tail and head, miss, dequeue
  task automatic test_full_queue();
    for (int i = 0; i < QDEPTH; i++) send_cmd(CMD_ENQ, i * 32'h1111_1111);
    send_cmd(CMD_ENQ, 32'h0000_1234);
    send_cmd(CMD_CONTAINS, 32'hffff_ffff);
    send_cmd(CMD_REMOVE, 32'hffff_ffff);
    send_cmd(CMD_REMOVE, 32'h0);
    send_cmd(CMD_REMOVE, 32'hdead_beef);
    send_cmd(CMD_DEQ, 32'h0);
  endtask

  // mixed commands, fill level drifts toward a moving target
  task automatic test_random_traffic(int n);
    int target;
    int enq_pct;
    int r;
    cmd_t c;
    target = QDEPTH / 2;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) target = $urandom_range(0, QDEPTH + 1);
      enq_pct = (stored_words.size() < target) ? 60 : 15;
      r = $urandom_range(0, 99);
      if (r < enq_pct) c = CMD_ENQ;
      else begin
        case (r % 3)
          0: c = CMD_DEQ;
          1: c = CMD_CONTAINS;
          default: c = CMD_REMOVE;
        endcase
      end
      send_cmd(c, pick_value(c != CMD_ENQ));
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_rx_backpressure();
    bit saved;
    saved = gaps_on;
    gaps_on = 1'b0;
    rx_hold = 1'b1;
    test_random_traffic(20);
    gaps_on = saved;
    wait_until_drained();
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_ENQ;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gaps_on = 1'b1;
    test_empty_queue();
    test_full_queue();
    test_random_traffic(500);
    test_rx_backpressure();
    test_random_traffic(500);
    wait_until_drained();
    gaps_on = 1'b0;
    test_random_traffic(250);
    wait_until_drained();
    if (pending_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0", $time,
               pending_results.size());
    end
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
src/fwsr_pkg.sv
src/fwsr_datapath.sv
src/fwsr_ctrl.sv
src/fifo_with_search_and_remove.sv
tb/fifo_with_search_and_remove_test.sv
